>>> src/tilt_motion_alarm_unit_assert.svh
// Assertion macros for the tilt and motion alarm unit.
// Stand-alone header; users need signals named aclk and aresetn in scope.
`ifndef TILT_MOTION_ALARM_UNIT_ASSERT_SVH
`define TILT_MOTION_ALARM_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TMA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tma_pkg.sv
// Shared types, constants and the arctangent table for the tilt and motion alarm unit.
// No dependencies.
package tma_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int SQRT_STEPS   = 16;
    localparam int STEP_W       = 5;
    localparam int CX_W         = 36;
    localparam int ACC_W        = 24;
    localparam int ANG_W        = 15;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 24'sd2304000;
    localparam logic [ANG_W-1:0] ANGLE_HALF_TURN = 15'd18000;
    localparam logic [14:0] THR_RESET = 15'd1000;
    localparam logic [20:0] DIV41_MUL = 21'd1636802;
    localparam int DIV41_SHIFT = 26;
    localparam logic [15:0] DIV10_MUL = 16'd52429;
    localparam int DIV10_SHIFT = 19;

    localparam logic REG_TILT_THR = 1'b0;
    localparam logic REG_RATE_THR = 1'b1;

    typedef enum logic [1:0] {
        CMD_SAMPLE       = 2'd0,
        CMD_CLEAR_ALARM  = 2'd1,
        CMD_CLEAR_REPORT = 2'd2,
        CMD_UNUSED       = 2'd3
    } cmd_code_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_SQRT_INIT, ST_SQRT, ST_CORD_INIT, ST_CORD, ST_STORE,
        ST_FIN1, ST_FIN2
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_SQ, OP_SQRT_INIT, OP_SQRT, OP_CORD_INIT, OP_CORD,
        OP_STORE, OP_FIN1, OP_FIN2
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [1:0]        sel;
        logic [STEP_W-1:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic is_sample;
        logic accel_zero;
        logic out_busy;
    } dp_status_t;

    // Arctangent of 2^-i in units of 1/25600 degree.
    function automatic logic [20:0] atan_unit(input logic [STEP_W-1:0] i);
        logic [20:0] v;
        unique case (i)
            5'd0:  v = 21'd1152000;
            5'd1:  v = 21'd680065;
            5'd2:  v = 21'd359328;
            5'd3:  v = 21'd182400;
            5'd4:  v = 21'd91554;
            5'd5:  v = 21'd45822;
            5'd6:  v = 21'd22916;
            5'd7:  v = 21'd11459;
            5'd8:  v = 21'd5730;
            5'd9:  v = 21'd2865;
            5'd10: v = 21'd1432;
            5'd11: v = 21'd716;
            5'd12: v = 21'd358;
            5'd13: v = 21'd179;
            5'd14: v = 21'd90;
            5'd15: v = 21'd45;
            5'd16: v = 21'd22;
            5'd17: v = 21'd11;
            5'd18: v = 21'd6;
            5'd19: v = 21'd3;
            5'd20: v = 21'd1;
            5'd21: v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

>>> src/tma_datapath.sv
// Datapath: sample registers, squarer, bit-serial square root, CORDIC, alarm state
// and the result register. Depends on tma_pkg.
module tma_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tma_pkg::dp_cmd_t     cmd,
    output tma_pkg::dp_status_t  status,
    input  logic [95:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_index,
    input  logic [14:0]          cfg_data,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [95:0]          m_tdata
);
    import tma_pkg::*;

    cmd_code_t cmd_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;
    logic [30:0] sq_reg [3];
    logic [19:0] p25_reg;
    logic [14:0] peak_reg;
    logic [31:0] rad_reg;
    logic [32:0] root_reg;
    logic [31:0] bit_reg;
    logic signed [CX_W-1:0] cx_reg, cy_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic yzero_reg;
    logic [ANG_W-1:0] cur_x_reg, cur_y_reg, cur_z_reg, ref_x_reg, ref_y_reg;
    logic ref_valid_reg, alarm_reg, pending_reg;
    logic [14:0] change_reg;
    logic [14:0] thr_tilt_reg, thr_rate_reg;
    logic m_tvalid_reg;
    logic [95:0] m_tdata_reg;

    logic [15:0] abs_ax, abs_ay, abs_az, abs_gx, abs_gy, abs_gz, gmax;
    logic signed [15:0] sq_op;
    logic signed [31:0] sq_prod;
    logic [40:0] peak_prod;
    logic [32:0] trial;
    logic [15:0] cord_xx, cord_yy;
    logic signed [CX_W-1:0] dx, dy;
    logic signed [ACC_W-1:0] t_step, acc_clamped, acc_round;
    logic [13:0] ang_mag;
    logic [ANG_W-1:0] ang_signed;
    logic signed [15:0] diff_x, diff_y;
    logic [15:0] mag_x, mag_y;
    logic [14:0] vmax;
    logic [30:0] vib_prod;
    logic sample_ok, trip;

    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        logic signed [16:0] w;
        w = v;
        if (w < 0) begin
            w = -w;
        end
        return w[15:0];
    endfunction

    assign abs_ax = abs16(ax_reg);
    assign abs_ay = abs16(ay_reg);
    assign abs_az = abs16(az_reg);
    assign abs_gx = abs16(gx_reg);
    assign abs_gy = abs16(gy_reg);
    assign abs_gz = abs16(gz_reg);

    always_comb begin
        gmax = abs_gx;
        if (abs_gy > gmax) begin
            gmax = abs_gy;
        end
        if (abs_gz > gmax) begin
            gmax = abs_gz;
        end
    end

    always_comb begin
        unique case (cmd.sel)
            2'd0:    sq_op = ax_reg;
            2'd1:    sq_op = ay_reg;
            default: sq_op = az_reg;
        endcase
    end
    assign sq_prod   = sq_op * sq_op;
    assign peak_prod = p25_reg * DIV41_MUL;
    assign trial     = root_reg + {1'b0, bit_reg};

    always_comb begin
        unique case (cmd.sel)
            2'd0: begin
                cord_xx = root_reg[15:0];
                cord_yy = abs_ax;
            end
            2'd1: begin
                cord_xx = root_reg[15:0];
                cord_yy = abs_ay;
            end
            default: begin
                cord_xx = abs_az;
                cord_yy = root_reg[15:0];
            end
        endcase
    end

    assign dx     = cy_reg >>> cmd.step;
    assign dy     = cx_reg >>> cmd.step;
    assign t_step = ACC_W'(atan_unit(cmd.step));

    always_comb begin
        if (acc_reg < 0) begin
            acc_clamped = '0;
        end else if (acc_reg > ACC_MAX) begin
            acc_clamped = ACC_MAX;
        end else begin
            acc_clamped = acc_reg;
        end
        acc_round = (acc_clamped + ACC_W'(128)) >>> 8;
        ang_mag   = yzero_reg ? 14'd0 : acc_round[13:0];
        unique case (cmd.sel)
            2'd0:    ang_signed = ax_reg[15] ? ANG_W'(0) - {1'b0, ang_mag} : {1'b0, ang_mag};
            2'd1:    ang_signed = ay_reg[15] ? ANG_W'(0) - {1'b0, ang_mag} : {1'b0, ang_mag};
            default: ang_signed = az_reg[15] ? ANGLE_HALF_TURN - {1'b0, ang_mag}
                                             : {1'b0, ang_mag};
        endcase
    end

    assign diff_x = {cur_x_reg[14], cur_x_reg} - {ref_x_reg[14], ref_x_reg};
    assign diff_y = {cur_y_reg[14], cur_y_reg} - {ref_y_reg[14], ref_y_reg};
    assign mag_x  = abs16(diff_x);
    assign mag_y  = abs16(diff_y);

    assign sample_ok = (cmd_reg == CMD_SAMPLE) && !status.accel_zero;
    assign vmax      = (change_reg > peak_reg) ? change_reg : peak_reg;
    assign vib_prod  = vmax * DIV10_MUL;
    assign trip      = !alarm_reg && ((change_reg >= thr_tilt_reg) || (peak_reg >= thr_rate_reg));

    assign status.is_sample  = (cmd_reg == CMD_SAMPLE);
    assign status.accel_zero = (ax_reg == 16'sd0) && (ay_reg == 16'sd0) && (az_reg == 16'sd0);
    assign status.out_busy   = m_tvalid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_tilt_reg  <= THR_RESET;
            thr_rate_reg  <= THR_RESET;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            cur_z_reg     <= '0;
            ref_x_reg     <= '0;
            ref_y_reg     <= '0;
            ref_valid_reg <= 1'b0;
            alarm_reg     <= 1'b0;
            pending_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_TILT_THR) begin
                    thr_tilt_reg <= cfg_data;
                end else begin
                    thr_rate_reg <= cfg_data;
                end
            end
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cmd.op == OP_STORE) begin
                unique case (cmd.sel)
                    2'd0:    cur_x_reg <= ang_signed;
                    2'd1:    cur_y_reg <= ang_signed;
                    default: cur_z_reg <= ang_signed;
                endcase
            end
            if (cmd.op == OP_FIN2) begin
                m_tvalid_reg <= 1'b1;
                unique case (cmd_reg)
                    CMD_SAMPLE: begin
                        if (sample_ok) begin
                            ref_valid_reg <= 1'b1;
                            ref_x_reg     <= cur_x_reg;
                            ref_y_reg     <= cur_y_reg;
                        end
                        if (trip) begin
                            alarm_reg   <= 1'b1;
                            pending_reg <= 1'b1;
                        end
                    end
                    CMD_CLEAR_ALARM: begin
                        alarm_reg     <= 1'b0;
                        pending_reg   <= 1'b0;
                        ref_x_reg     <= '0;
                        ref_y_reg     <= '0;
                        ref_valid_reg <= 1'b0;
                    end
                    CMD_CLEAR_REPORT: pending_reg <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                cmd_reg <= cmd_code_t'(s_tuser);
                ax_reg  <= s_tdata[15:0];
                ay_reg  <= s_tdata[31:16];
                az_reg  <= s_tdata[47:32];
                gx_reg  <= s_tdata[63:48];
                gy_reg  <= s_tdata[79:64];
                gz_reg  <= s_tdata[95:80];
            end
            OP_SQ: begin
                sq_reg[cmd.sel] <= sq_prod[30:0];
                if (cmd.sel == 2'd0) begin
                    p25_reg <= {gmax, 4'd0} + {1'b0, gmax, 3'd0} + {4'd0, gmax};
                end
                if (cmd.sel == 2'd1) begin
                    peak_reg <= peak_prod[DIV41_SHIFT +: 15];
                end
            end
            OP_SQRT_INIT: begin
                unique case (cmd.sel)
                    2'd0:    rad_reg <= {1'b0, sq_reg[1]} + {1'b0, sq_reg[2]};
                    2'd1:    rad_reg <= {1'b0, sq_reg[0]} + {1'b0, sq_reg[2]};
                    default: rad_reg <= {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]};
                endcase
                root_reg <= '0;
                bit_reg  <= 32'h4000_0000;
            end
            OP_SQRT: begin
                if ({1'b0, rad_reg} >= trial) begin
                    rad_reg  <= rad_reg - trial[31:0];
                    root_reg <= (root_reg >> 1) + {1'b0, bit_reg};
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_CORD_INIT: begin
                cx_reg    <= $signed({{(CX_W-32){1'b0}}, cord_xx, 16'd0});
                cy_reg    <= $signed({{(CX_W-32){1'b0}}, cord_yy, 16'd0});
                acc_reg   <= '0;
                yzero_reg <= (cord_yy == 16'd0);
            end
            OP_CORD: begin
                if (!cy_reg[CX_W-1]) begin
                    cx_reg  <= cx_reg + dx;
                    cy_reg  <= cy_reg - dy;
                    acc_reg <= acc_reg + t_step;
                end else begin
                    cx_reg  <= cx_reg - dx;
                    cy_reg  <= cy_reg + dy;
                    acc_reg <= acc_reg - t_step;
                end
            end
            OP_FIN1: begin
                if (sample_ok && ref_valid_reg) begin
                    change_reg <= (mag_x > mag_y) ? mag_x[14:0] : mag_y[14:0];
                end else begin
                    change_reg <= '0;
                end
            end
            OP_FIN2: begin
                m_tdata_reg[14:0]  <= cur_x_reg;
                m_tdata_reg[29:15] <= cur_y_reg;
                m_tdata_reg[44:30] <= cur_z_reg;
                m_tdata_reg[95:89] <= '0;
                if (cmd_reg == CMD_SAMPLE) begin
                    m_tdata_reg[59:45] <= change_reg;
                    m_tdata_reg[74:60] <= peak_reg;
                    m_tdata_reg[85:75] <= vib_prod[DIV10_SHIFT +: 11];
                    m_tdata_reg[86]    <= alarm_reg || trip;
                    m_tdata_reg[87]    <= pending_reg || trip;
                    m_tdata_reg[88]    <= trip;
                end else begin
                    m_tdata_reg[59:45] <= '0;
                    m_tdata_reg[74:60] <= '0;
                    m_tdata_reg[85:75] <= '0;
                    m_tdata_reg[86]    <= alarm_reg && (cmd_reg != CMD_CLEAR_ALARM);
                    m_tdata_reg[87]    <= pending_reg && (cmd_reg == CMD_UNUSED);
                    m_tdata_reg[88]    <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> src/tma_ctrl.sv
// Controller: sequences load, squaring, square roots, CORDIC passes and the result.
// Depends on tma_pkg.
module tma_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  tma_pkg::dp_status_t  status,
    output tma_pkg::dp_cmd_t     cmd
);
    import tma_pkg::*;

    state_t state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SQ;
                    sel_next   = '0;
                end
            end
            ST_SQ: begin
                if (sel_reg == 2'd2) begin
                    sel_next   = '0;
                    state_next = (status.is_sample && !status.accel_zero) ? ST_SQRT_INIT
                                                                          : ST_FIN1;
                end else begin
                    sel_next = sel_reg + 2'd1;
                end
            end
            ST_SQRT_INIT: begin
                state_next = ST_SQRT;
                step_next  = '0;
            end
            ST_SQRT: begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_CORD_INIT;
                end
            end
            ST_CORD_INIT: begin
                state_next = ST_CORD;
                step_next  = '0;
            end
            ST_CORD: begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CORDIC_N - 1)) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                if (sel_reg == 2'd2) begin
                    state_next = ST_FIN1;
                end else begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = ST_SQRT_INIT;
                end
            end
            ST_FIN1: state_next = ST_FIN2;
            ST_FIN2: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd.op   = OP_NONE;
        cmd.sel  = sel_reg;
        cmd.step = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_SQ:        cmd.op = OP_SQ;
            ST_SQRT_INIT: cmd.op = OP_SQRT_INIT;
            ST_SQRT:      cmd.op = OP_SQRT;
            ST_CORD_INIT: cmd.op = OP_CORD_INIT;
            ST_CORD:      cmd.op = OP_CORD;
            ST_STORE:     cmd.op = OP_STORE;
            ST_FIN1:      cmd.op = OP_FIN1;
            ST_FIN2: begin
                if (!status.out_busy) begin
                    cmd.op = OP_FIN2;
                end
            end
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule

>>> src/tilt_motion_alarm_unit.sv
// Top level of the tilt and motion alarm unit: controller plus datapath.
// Depends on tma_pkg, tma_ctrl and tma_datapath.
//
// One request is taken at a time. A sample request with a non-zero accelerometer
// reading runs a load, three squaring steps, then per tilt angle a square-root
// setup, 16 square-root steps, a CORDIC setup, 16 CORDIC steps and a store, then
// two finishing steps; the last waits while an earlier result is not yet taken.
// The square-root and CORDIC unit is shared by the three angles. Command requests
// and all-zero accelerometer samples skip the square roots and CORDIC passes. The
// result sits in an output register; the next request is accepted while it waits.
module tilt_motion_alarm_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, 16 bits each
    input  logic [95:0] s_tdata,
    // command
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // angle_x, angle_y, angle_z, angle_change, rate_peak (15 bits each),
    // vibration (11), latched, report_pending, newly_tripped, 7 zero bits
    output logic [95:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [14:0] cfg_data
);
    import tma_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    tma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    tma_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

>>> src/tma_checker.sv
// Port-level checks for the tilt and motion alarm unit, bound to the top level.
// Depends on tilt_motion_alarm_unit_assert.svh.
`include "tilt_motion_alarm_unit_assert.svh"

module tma_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    `TMA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `TMA_ASSERT_IMPLY(a_trip_sets_flags, m_tvalid && m_tdata[88], m_tdata[86] && m_tdata[87], "trip without latched flags")
    `TMA_ASSERT_IMPLY(a_pending_needs_alarm, m_tvalid && m_tdata[87], m_tdata[86], "report pending without alarm")
    `TMA_ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready, "ready right after a request")

endmodule

bind tilt_motion_alarm_unit tma_checker u_tma_checker (.*);

>>> dv/tilt_motion_alarm_unit_tb.sv
// Self-checking testbench for tilt_motion_alarm_unit: directed and random IMU requests
// with threshold changes, checked against a tilt and gyro alarm predictor.
// Depends on tma_pkg and the tilt_motion_alarm_unit RTL.
module tilt_motion_alarm_unit_tb;
    import tma_pkg::*;

    typedef struct packed {
        logic signed [15:0] gz, gy, gx, az, ay, ax;
    } imu_sample_t;

    typedef struct {
        cmd_code_t   cmd;
        imu_sample_t smp;
    } imu_req_t;

    typedef struct packed {
        logic [6:0]  pad;
        logic        tripped;
        logic        pending;
        logic        latched;
        logic [10:0] vib;
        logic [14:0] peak;
        logic [14:0] change;
        logic [14:0] ang_z;
        logic [14:0] ang_y;
        logic [14:0] ang_x;
    } alarm_report_t;

    localparam int ATAN_LUT [24] = '{
        1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
        5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1, 0, 0
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [14:0] cfg_data;

    tilt_motion_alarm_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    imu_req_t      pending_reqs[$];
    alarm_report_t expected_reports[$];
    imu_req_t      req_on_bus;
    int            err_count;
    int            req_gap;
    int            stall_left;
    bit            idle_on;

    int  tilt_thr, rate_thr;
    int  ref_x, ref_y, cur_x, cur_y, cur_z;
    bit  ref_ok, alarm_on, report_on;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("** tilt_motion_alarm_unit: FAILED **");
        $finish;
    end

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 32;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic int cordic_angle(longint xx, longint yy);
        longint x, y, dx, dy, acc;
        x = xx <<< 16;
        y = yy <<< 16;
        acc = 0;
        if (yy == 0) return 0;
        for (int i = 0; i < CORDIC_N; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                acc = acc + ATAN_LUT[i];
            end else begin
                x = x - dx;
                y = y + dy;
                acc = acc - ATAN_LUT[i];
            end
        end
        if (acc < 0) acc = 0;
        if (acc > 2304000) acc = 2304000;
        return int'((acc + 128) >>> 8);
    endfunction

    function automatic longint abs_l(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic alarm_report_t predict_report(imu_req_t r);
        alarm_report_t rep;
        longint ax, ay, az, gm, a;
        int change, peak, vib;
        bit tripped;
        change = 0;
        peak = 0;
        tripped = 0;
        rep = '0;
        case (r.cmd)
            CMD_SAMPLE: begin
                ax = r.smp.ax;
                ay = r.smp.ay;
                az = r.smp.az;
                gm = abs_l(r.smp.gx);
                if (abs_l(r.smp.gy) > gm) gm = abs_l(r.smp.gy);
                if (abs_l(r.smp.gz) > gm) gm = abs_l(r.smp.gz);
                peak = int'(gm * 25 / 41);
                if (ax != 0 || ay != 0 || az != 0) begin
                    a = cordic_angle(floor_sqrt(ay * ay + az * az), abs_l(ax));
                    cur_x = (ax < 0) ? -a : a;
                    a = cordic_angle(floor_sqrt(ax * ax + az * az), abs_l(ay));
                    cur_y = (ay < 0) ? -a : a;
                    a = cordic_angle(abs_l(az), floor_sqrt(ax * ax + ay * ay));
                    cur_z = (az < 0) ? 18000 - a : a;
                    if (ref_ok) begin
                        change = int'(abs_l(cur_x - ref_x));
                        if (abs_l(cur_y - ref_y) > change) change = int'(abs_l(cur_y - ref_y));
                    end else begin
                        ref_ok = 1;
                    end
                    ref_x = cur_x;
                    ref_y = cur_y;
                end
                if (!alarm_on && (change >= tilt_thr || peak >= rate_thr)) begin
                    alarm_on = 1;
                    report_on = 1;
                    tripped = 1;
                end
            end
            CMD_CLEAR_ALARM: begin
                alarm_on = 0;
                report_on = 0;
                ref_x = 0;
                ref_y = 0;
                ref_ok = 0;
            end
            CMD_CLEAR_REPORT: report_on = 0;
            default: ;
        endcase
        vib = change / 10;
        if (peak / 10 > vib) vib = peak / 10;
        rep.ang_x = cur_x[14:0];
        rep.ang_y = cur_y[14:0];
        rep.ang_z = cur_z[14:0];
        rep.change = change[14:0];
        rep.peak = peak[14:0];
        rep.vib = vib[10:0];
        rep.latched = alarm_on;
        rep.pending = report_on;
        rep.tripped = tripped;
        return rep;
    endfunction

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Request driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            req_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) expected_reports.push_back(predict_report(req_on_bus));
            if (!s_tvalid || s_tready) begin
                if (req_gap > 0) begin
                    req_gap <= req_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    req_on_bus = pending_reqs.pop_front();
                    s_tdata <= req_on_bus.smp;
                    s_tuser <= req_on_bus.cmd;
                    s_tvalid <= 1'b1;
                    req_gap <= next_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, int e, int a);
        if (e != a) begin
            err_count++;
            if (err_count <= 10)
                $display("mismatch %s: expected %0d actual %0d", name, e, a);
        end
    endtask

    // Result monitor with random back-pressure.
    always @(posedge aclk) begin
        alarm_report_t act, exp_rep;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                act = m_tdata;
                if (expected_reports.size() == 0) begin
                    err_count++;
                    if (err_count <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    exp_rep = expected_reports.pop_front();
                    check_field("angle_x", exp_rep.ang_x, act.ang_x);
                    check_field("angle_y", exp_rep.ang_y, act.ang_y);
                    check_field("angle_z", exp_rep.ang_z, act.ang_z);
                    check_field("angle_change", exp_rep.change, act.change);
                    check_field("rate_peak", exp_rep.peak, act.peak);
                    check_field("vibration", exp_rep.vib, act.vib);
                    check_field("latched", exp_rep.latched, act.latched);
                    check_field("report_pending", exp_rep.pending, act.pending);
                    check_field("newly_tripped", exp_rep.tripped, act.tripped);
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                stall_left <= next_gap();
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic idx, int val);
        cfg_index <= idx;
        cfg_data <= val[14:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_TILT_THR) tilt_thr = val;
        else rate_thr = val;
    endtask

    task automatic add_req(cmd_code_t c, int ax, int ay, int az, int gx, int gy, int gz);
        imu_req_t r;
        r.cmd = c;
        r.smp.ax = ax[15:0];
        r.smp.ay = ay[15:0];
        r.smp.az = az[15:0];
        r.smp.gx = gx[15:0];
        r.smp.gy = gy[15:0];
        r.smp.gz = gz[15:0];
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_tvalid || expected_reports.size() > 0)
            @(posedge aclk);
        repeat (130) @(posedge aclk);
    endtask

    function automatic int rand_full();
        return $signed($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int rand_gyro();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $signed($urandom_range(0, 2000)) - 1000;
        if (r < 90) return $signed($urandom_range(0, 8000)) - 4000;
        return rand_full();
    endfunction

    task automatic add_random_reqs(int n);
        int r, g, ax, ay, az;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                add_req(CMD_CLEAR_ALARM, rand_full(), rand_full(), rand_full(), 0, 0, 0);
            end else if (r < 11) begin
                add_req(CMD_CLEAR_REPORT, rand_full(), 0, 0, rand_full(), 0, 0);
            end else if (r < 13) begin
                add_req(CMD_UNUSED, rand_full(), rand_full(), 0, 0, 0, rand_full());
            end else if (r < 16) begin
                add_req(CMD_SAMPLE, 0, 0, 0, rand_gyro(), rand_gyro(), rand_gyro());
            end else if (r < 40) begin
                add_req(CMD_SAMPLE, rand_full(), rand_full(), rand_full(),
                        rand_full(), rand_full(), rand_full());
            end else begin
                // Mostly gravity-sized readings with some movement.
                g = $urandom_range(0, 2);
                ax = $signed($urandom_range(0, 6000)) - 3000;
                ay = $signed($urandom_range(0, 6000)) - 3000;
                az = ($urandom_range(0, 9) == 0) ? -16384 : 16384;
                az = az + $signed($urandom_range(0, 4000)) - 2000;
                if (g == 1) ax = ax * 5;
                add_req(CMD_SAMPLE, ax, ay, az, rand_gyro(), rand_gyro(), rand_gyro());
            end
        end
    endtask

    initial begin
        int tilt_set [6] = '{1000, 0, 32767, 18000, 300, 2500};
        int rate_set [6] = '{1000, 32767, 0, 19980, 5000, 1500};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_SAMPLE;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_TILT_THR;
        cfg_data = '0;
        err_count = 0;
        idle_on = 1;
        tilt_thr = 1000;
        rate_thr = 1000;
        {ref_x, ref_y, cur_x, cur_y, cur_z} = '0;
        {ref_ok, alarm_on, report_on} = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset thresholds.
        add_req(CMD_SAMPLE, 0, 0, 0, 0, 0, 0);
        add_req(CMD_SAMPLE, 0, 0, 16384, 10, -10, 5);
        add_req(CMD_SAMPLE, 0, 0, 16384, 0, 0, 0);
        add_req(CMD_SAMPLE, 32767, 0, 0, 0, 0, 0);
        add_req(CMD_CLEAR_REPORT, 0, 0, 0, 0, 0, 0);
        add_req(CMD_SAMPLE, -32768, -32768, -32768, -32768, 32767, -32768);
        add_req(CMD_CLEAR_ALARM, -1, -1, -1, -1, -1, -1);
        add_req(CMD_SAMPLE, 0, 0, -32768, 0, -32768, 0);
        add_req(CMD_CLEAR_ALARM, 0, 0, 0, 0, 0, 0);
        add_req(CMD_SAMPLE, 32767, 32767, 32767, 0, 0, 32767);
        add_req(CMD_CLEAR_ALARM, 0, 0, 0, 0, 0, 0);
        add_req(CMD_SAMPLE, 0, -32768, 0, 1639, 0, 0);
        add_req(CMD_SAMPLE, 0, 0, 0, 1640, 0, 0);
        add_req(CMD_SAMPLE, 0, 0, 0, 0, 0, 0);
        add_req(CMD_UNUSED, 32767, 32767, 32767, 32767, 32767, 32767);
        add_req(CMD_CLEAR_REPORT, 0, 0, 0, 0, 0, 0);
        add_req(CMD_CLEAR_ALARM, 0, 0, 0, 0, 0, 0);
        add_req(CMD_SAMPLE, 1, -1, 0, -1, 1, -1);
        add_req(CMD_SAMPLE, -1, 1, 0, 0, 0, 0);
        add_req(CMD_SAMPLE, 5000, 0, 16000, 0, 0, 0);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            idle_on = (p != 3);
            write_reg(REG_TILT_THR, tilt_set[p]);
            write_reg(REG_RATE_THR, rate_set[p]);
            add_random_reqs(215);
            wait_drained();
        end

        if (err_count == 0 && expected_reports.size() == 0) begin
            $display("** tilt_motion_alarm_unit: PASSED **");
        end else begin
            $display("** tilt_motion_alarm_unit: FAILED **");
        end
        $finish;
    end
endmodule
